/* src/bru_pkg.sv */
// Shared types and codes for the byte register ALU with stack.
`default_nettype none
package bru_pkg;

  // Instruction codes
  localparam logic [4:0] CMD_LDI  = 5'd1;
  localparam logic [4:0] CMD_ADD  = 5'd2;
  localparam logic [4:0] CMD_PUSH = 5'd3;
  localparam logic [4:0] CMD_POP  = 5'd4;
  localparam logic [4:0] CMD_MOV  = 5'd5;
  localparam logic [4:0] CMD_SUB  = 5'd6;
  localparam logic [4:0] CMD_MUL  = 5'd7;
  localparam logic [4:0] CMD_DIV  = 5'd8;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIV0    = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [7:0]  a;
    logic [7:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  result;
    logic        carry;
  } alu_rsp_t;

  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage
`default_nettype wire

/* src/bru_if.sv */
// Valid/ready channel interfaces for instructions and results.
`default_nettype none
interface bru_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        command;
  logic [2:0]        dest_reg;
  logic [2:0]        src_reg;
  logic signed [7:0] immediate;

  modport source (output valid, output command, output dest_reg, output src_reg,
                  output immediate, input ready);
  modport sink   (input valid, input command, input dest_reg, input src_reg,
                  input immediate, output ready);
endinterface

interface bru_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] result_value;
  logic              zero_flag;
  logic              carry_flag;
  logic              overflow_flag;
  logic              underflow_flag;
  logic [3:0]        stack_depth;
  logic [2:0]        status;

  modport source (output valid, output result_value, output zero_flag,
                  output carry_flag, output overflow_flag, output underflow_flag,
                  output stack_depth, output status, input ready);
  modport sink   (input valid, input result_value, input zero_flag,
                  input carry_flag, input overflow_flag, input underflow_flag,
                  input stack_depth, input status, output ready);
endinterface
`default_nettype wire

/* src/bru_alu.sv */
// Shared arithmetic unit: add, subtract and multiply directly, divide by eight restoring steps.
`default_nettype none
module bru_alu (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bru_pkg::alu_req_t req,
  output bru_pkg::alu_rsp_t  rsp
);

  typedef enum logic {A_IDLE, A_DIV} astate_t;

  astate_t     state;
  logic [7:0]  rem;
  logic [7:0]  quo;
  logic [7:0]  divisor;
  logic        neg;
  logic [2:0]  cnt;

  logic [7:0]  op2;
  logic [8:0]  sum9;
  logic        carry;
  logic [15:0] prod;
  logic [7:0]  mag_a;
  logic [7:0]  mag_b;
  logic [8:0]  shifted;
  logic [7:0]  rem_next;
  logic [7:0]  quo_next;

  // Subtract adds the 8-bit negation of the second operand
  assign op2   = (req.op == bru_pkg::ALU_SUB) ? 8'(-req.b) : req.b;
  assign sum9  = {req.a[7], req.a} + {op2[7], op2};
  assign carry = sum9[8] != sum9[7];
  assign prod  = req.a * req.b;
  assign mag_a = req.a[7] ? 8'(-req.a) : req.a;
  assign mag_b = req.b[7] ? 8'(-req.b) : req.b;

  // One restoring step
  always_comb begin
    shifted = {rem, quo[7]};
    if (shifted >= {1'b0, divisor}) begin
      rem_next = 8'(shifted - {1'b0, divisor});
      quo_next = {quo[6:0], 1'b1};
    end else begin
      rem_next = shifted[7:0];
      quo_next = {quo[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            rsp.carry <= carry;
            unique case (req.op)
              bru_pkg::ALU_ADD, bru_pkg::ALU_SUB: begin
                rsp.result <= sum9[7:0];
                rsp.done   <= 1'b1;
              end
              bru_pkg::ALU_MUL: begin
                rsp.result <= prod[7:0];
                rsp.done   <= 1'b1;
              end
              bru_pkg::ALU_DIV: begin
                rem     <= 8'd0;
                quo     <= mag_a;
                divisor <= mag_b;
                neg     <= req.a[7] ^ req.b[7];
                cnt     <= 3'd0;
                state   <= A_DIV;
              end
            endcase
          end
        end
        A_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            rsp.result <= neg ? 8'(-quo_next) : quo_next;
            rsp.done   <= 1'b1;
            state      <= A_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/bru_regfile.sv */
// Register file memory with two registered read ports and reset-cleared valid bits.
`default_nettype none
module bru_regfile #(
  parameter int REGISTER_COUNT = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(REGISTER_COUNT)-1:0] rd_addr_a,
  input  wire logic [$clog2(REGISTER_COUNT)-1:0] rd_addr_b,
  output logic [7:0]                             rd_data_a,
  output logic [7:0]                             rd_data_b,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(REGISTER_COUNT)-1:0] wr_addr,
  input  wire logic [7:0]                        wr_data
);

  logic [7:0]                mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= valid[rd_addr_a] ? mem[rd_addr_a] : 8'd0;
      rd_data_b <= valid[rd_addr_b] ? mem[rd_addr_b] : 8'd0;
    end
  end

endmodule
`default_nettype wire

/* src/bru_stack.sv */
// Byte stack memory with its pointer.
`default_nettype none
module bru_stack #(
  parameter int STACK_ENTRIES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bru_pkg::stk_ctl_t                  ctl,
  input  wire logic [7:0]                         wr_data,
  output logic [7:0]                              rd_data,
  output logic [$clog2(STACK_ENTRIES+1)-1:0]      sp
);

  localparam int PW = $clog2(STACK_ENTRIES + 1);
  localparam int SW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

  logic [7:0]    mem [STACK_ENTRIES];
  logic [PW-1:0] sp_m1;

  assign sp_m1 = sp - PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctl.push) begin
      sp <= sp + PW'(1);
    end else if (ctl.pop) begin
      sp <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[sp[SW-1:0]] <= wr_data;
    end
  end

  // Top of stack, fetched ahead of a possible pop
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[sp_m1[SW-1:0]];
    end
  end

endmodule
`default_nettype wire

/* src/byte_register_alu_with_stack_top.sv */
// Top level: instruction sequencer around the register file, stack and shared ALU.
//
// Channels: instructions arrive on instr (command, dest_reg, src_reg, immediate);
// one result per instruction leaves on outcome (result_value, four flags,
// stack_depth, status). A transfer happens when valid and ready are both high.
// The block takes one instruction at a time: instr.ready is high only while
// the sequencer is idle.
// Steps per instruction, from accept to the next accept:
//   load immediate, move, push, pop and every error case: accept, operand, commit
//   add, subtract, multiply: accept, operand, ALU wait, commit
//   divide: as add, with the eight restoring steps of the shared ALU in the wait
// The result appears on outcome in the cycle after the last internal step.
// Reset clears the registers' valid bits (they read as zero), the stack
// pointer, the flags and the sequencer.
// A stalled receiver holds the result in the output register; a finished
// instruction waits there until the register is free, and only then are its
// register, stack and flag updates committed.
`default_nettype none
module byte_register_alu_with_stack_top #(
  parameter int STACK_ENTRIES  = 8,
  parameter int REGISTER_COUNT = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bru_in_if.sink     instr,
  bru_out_if.source  outcome
);

  localparam int RW = $clog2(REGISTER_COUNT);
  localparam int PW = $clog2(STACK_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_OPER, S_WAIT, S_EMIT} state_t;

  typedef struct packed {
    logic u;
    logic o;
    logic c;
    logic z;
  } flags_t;

  // Fold a register index into the implemented range
  function automatic logic [RW-1:0] reg_index(input logic [2:0] v);
    logic [4:0] t;
    t = {2'b00, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= 5'(REGISTER_COUNT)) begin
        t = t - 5'(REGISTER_COUNT);
      end
    end
    return t[RW-1:0];
  endfunction

  function automatic flags_t value_flags(input logic signed [7:0] v, input logic c);
    flags_t f;
    f.z = (v == 8'sd0);
    f.o = (v > 8'sd125);
    f.u = (v < -8'sd125);
    f.c = c;
    return f;
  endfunction

  state_t            state;
  logic [4:0]        cmd_q;
  logic [RW-1:0]     dst_q;
  logic [7:0]        imm_q;
  logic [7:0]        res_q;
  flags_t            new_flags_q;
  logic              flags_upd_q;
  logic              rf_we_q;
  logic              push_q;
  logic              pop_q;
  logic [2:0]        status_q;
  flags_t            flags;

  logic              out_valid;
  logic [7:0]        out_res;
  flags_t            out_flags;
  logic [3:0]        out_depth;
  logic [2:0]        out_status;

  logic              accept;
  logic              commit;
  logic [7:0]        v1;
  logic [7:0]        v2;
  logic [7:0]        stk_top;
  logic [PW-1:0]     sp;
  logic [PW-1:0]     sp_after;
  logic [PW+3:0]     sp_wide;
  logic              stk_full;
  logic              stk_empty;
  logic              arith;
  bru_pkg::alu_req_t alu_req;
  bru_pkg::alu_rsp_t alu_rsp;
  bru_pkg::stk_ctl_t stk_ctl;

  assign accept    = instr.valid && instr.ready;
  assign commit    = (state == S_EMIT) && (!out_valid || outcome.ready);
  assign instr.ready = (state == S_IDLE);
  assign stk_full  = (sp >= PW'(STACK_ENTRIES));
  assign stk_empty = (sp == '0);

  assign arith = (cmd_q == bru_pkg::CMD_ADD) || (cmd_q == bru_pkg::CMD_SUB) ||
                 (cmd_q == bru_pkg::CMD_MUL) ||
                 ((cmd_q == bru_pkg::CMD_DIV) && (v2 != 8'd0));

  always_comb begin
    alu_req.start = (state == S_OPER) && arith;
    alu_req.a     = v1;
    alu_req.b     = v2;
    priority case (cmd_q)
      bru_pkg::CMD_SUB: alu_req.op = bru_pkg::ALU_SUB;
      bru_pkg::CMD_MUL: alu_req.op = bru_pkg::ALU_MUL;
      bru_pkg::CMD_DIV: alu_req.op = bru_pkg::ALU_DIV;
      default:          alu_req.op = bru_pkg::ALU_ADD;
    endcase
  end

  assign stk_ctl.rd_en = accept;
  assign stk_ctl.push  = commit && push_q;
  assign stk_ctl.pop   = commit && pop_q;

  always_comb begin
    if (push_q) begin
      sp_after = sp + PW'(1);
    end else if (pop_q) begin
      sp_after = sp - PW'(1);
    end else begin
      sp_after = sp;
    end
  end
  assign sp_wide = {4'b0000, sp_after};

  bru_regfile #(.REGISTER_COUNT(REGISTER_COUNT)) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (reg_index(instr.dest_reg)),
    .rd_addr_b (reg_index(instr.src_reg)),
    .rd_data_a (v1),
    .rd_data_b (v2),
    .wr_en     (commit && rf_we_q),
    .wr_addr   (dst_q),
    .wr_data   (res_q)
  );

  bru_stack #(.STACK_ENTRIES(STACK_ENTRIES)) u_stack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stk_ctl),
    .wr_data (res_q),
    .rd_data (stk_top),
    .sp      (sp)
  );

  bru_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && outcome.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= instr.command;
            dst_q <= reg_index(instr.dest_reg);
            imm_q <= instr.immediate;
            state <= S_OPER;
          end
        end
        S_OPER: begin
          // Operands are now out of the register file and stack
          res_q       <= 8'd0;
          new_flags_q <= flags;
          flags_upd_q <= 1'b0;
          rf_we_q     <= 1'b0;
          push_q      <= 1'b0;
          pop_q       <= 1'b0;
          status_q    <= bru_pkg::ST_OK;
          state       <= S_EMIT;
          priority case (cmd_q)
            bru_pkg::CMD_LDI: begin
              res_q       <= imm_q;
              new_flags_q <= value_flags(imm_q, 1'b0);
              flags_upd_q <= 1'b1;
              rf_we_q     <= 1'b1;
            end
            bru_pkg::CMD_MOV: begin
              res_q       <= v2;
              new_flags_q <= value_flags(v2, 1'b0);
              flags_upd_q <= 1'b1;
              rf_we_q     <= 1'b1;
            end
            bru_pkg::CMD_ADD, bru_pkg::CMD_SUB, bru_pkg::CMD_MUL: begin
              state <= S_WAIT;
            end
            bru_pkg::CMD_DIV: begin
              if (v2 == 8'd0) begin
                status_q <= bru_pkg::ST_DIV0;
              end else begin
                state <= S_WAIT;
              end
            end
            bru_pkg::CMD_PUSH: begin
              if (stk_full) begin
                status_q <= bru_pkg::ST_OVER;
              end else begin
                res_q  <= v1;
                push_q <= 1'b1;
              end
            end
            bru_pkg::CMD_POP: begin
              if (stk_empty) begin
                status_q <= bru_pkg::ST_UNDER;
              end else begin
                res_q   <= stk_top;
                pop_q   <= 1'b1;
                rf_we_q <= 1'b1;
              end
            end
            default: begin
              status_q <= bru_pkg::ST_UNKNOWN;
            end
          endcase
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            res_q       <= alu_rsp.result;
            new_flags_q <= value_flags(alu_rsp.result, alu_rsp.carry);
            flags_upd_q <= 1'b1;
            rf_we_q     <= 1'b1;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Commit only once the output register can take the result
          if (commit) begin
            if (flags_upd_q) begin
              flags <= new_flags_q;
            end
            out_valid  <= 1'b1;
            out_res    <= res_q;
            out_flags  <= flags_upd_q ? new_flags_q : flags;
            out_depth  <= sp_wide[3:0];
            out_status <= status_q;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign outcome.valid          = out_valid;
  assign outcome.result_value   = out_res;
  assign outcome.zero_flag      = out_flags.z;
  assign outcome.carry_flag     = out_flags.c;
  assign outcome.overflow_flag  = out_flags.o;
  assign outcome.underflow_flag = out_flags.u;
  assign outcome.stack_depth    = out_depth;
  assign outcome.status         = out_status;

  // An accepted instruction makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !instr.ready)
    else $error("ready stayed high after an accepted instruction");

  // The stack pointer never passes the stack size
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= PW'(STACK_ENTRIES))
    else $error("stack pointer beyond stack size");

  // The ALU answers only while the sequencer waits for it
  a_alu_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == S_WAIT)
    else $error("ALU result arrived outside the wait state");

  // A new result appears only from the commit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside the commit step");

endmodule
`default_nettype wire
